@@ hw/rtl/pkc_pkg.sv @@
// ----------------------------------------------------------------------------
// pkc_pkg: shared types and constants for the preset kernel convolution
// Pixel and result item types, window record passed down the MAC chain,
// filter mode codes, register map and the 3x3 kernel table.
// ----------------------------------------------------------------------------
package pkc_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int RAM_DEPTH   = 2 * MAX_WIDTH;
  localparam int PTR_W       = $clog2(RAM_DEPTH);
  localparam int WID_W       = $clog2(MAX_WIDTH) + 1;
  localparam int CNT_W       = 21;
  localparam int SUM_W       = 13;
  localparam int COEF_W      = 5;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int NCELL       = 9;   // one MAC cell per kernel tap

  localparam logic [CNT_W-1:0] CNT_MAX     = '1;
  localparam logic [WID_W-1:0] WIDTH_RESET = WID_W'(640);
  localparam logic [WID_W-1:0] WIDTH_MAX   = WID_W'(MAX_WIDTH);

  // floor(s / 9) == (s * 3641) >> 15 for 0 <= s < 4096
  localparam logic [SUM_W-2:0] DIV9_MUL   = (SUM_W-1)'(3641);
  localparam int               DIV9_SHIFT = 15;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    MODE_PASS    = 3'd0,
    MODE_BLUR    = 3'd1,
    MODE_EDGE    = 3'd2,
    MODE_EMBOSS  = 3'd3,
    MODE_SHARPEN = 3'd4,
    MODE_ENFORCE = 3'd5
  } pkc_mode_t;

  typedef enum logic {
    REG_FILTER_MODE = 1'b0,
    REG_IMAGE_WIDTH = 1'b1
  } pkc_reg_t;

  typedef struct packed {
    logic       cmd;
    logic       frame_start;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pkc_pix_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } pkc_res_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pkc_rgb_t;

  // three consecutive items, [0] newest
  typedef pkc_rgb_t [2:0] pkc_triple_t;

  typedef logic signed [SUM_W-1:0] pkc_sum_t;

  // one window on its way down the chain; sums [0] red, [1] green, [2] blue
  typedef struct packed {
    pkc_mode_t              mode;
    logic [2:0][2:0]        mask;
    pkc_triple_t [2:0]      taps;
    pkc_sum_t [2:0]         sums;
  } pkc_win_t;

  // kernel by [dy+1][dx+1]
  localparam logic signed [COEF_W-1:0] KERN [6][3][3] = '{
    '{'{ 5'sd0,  5'sd0,  5'sd0}, '{ 5'sd0,  5'sd1,  5'sd0}, '{ 5'sd0,  5'sd0,  5'sd0}},
    '{'{ 5'sd1,  5'sd1,  5'sd1}, '{ 5'sd1,  5'sd1,  5'sd1}, '{ 5'sd1,  5'sd1,  5'sd1}},
    '{'{-5'sd1, -5'sd1, -5'sd1}, '{-5'sd1,  5'sd8, -5'sd1}, '{-5'sd1, -5'sd1, -5'sd1}},
    '{'{-5'sd2, -5'sd1,  5'sd0}, '{-5'sd1,  5'sd1,  5'sd1}, '{ 5'sd0,  5'sd1,  5'sd2}},
    '{'{ 5'sd0, -5'sd1,  5'sd0}, '{-5'sd1,  5'sd5, -5'sd1}, '{ 5'sd0, -5'sd1,  5'sd0}},
    '{'{ 5'sd0, -5'sd1,  5'sd0}, '{ 5'sd0,  5'sd1,  5'sd0}, '{ 5'sd0,  5'sd0,  5'sd0}}
  };

  // row counts items back in lines (0 newest), col counts items back within a row
  function automatic logic signed [COEF_W-1:0] pkc_coef(input pkc_mode_t mode,
                                                        input logic [1:0] row,
                                                        input logic [1:0] col);
    logic [1:0] ky;
    logic [1:0] kx;
    ky = 2'd2 - row;
    kx = 2'd2 - col;
    return KERN[mode][ky][kx];
  endfunction

  function automatic pkc_mode_t pkc_mode_of(input logic [2:0] code);
    pkc_mode_t m;
    m = pkc_mode_t'(code);
    case (m)
      MODE_PASS, MODE_BLUR, MODE_EDGE, MODE_EMBOSS, MODE_SHARPEN, MODE_ENFORCE: return m;
      default: return MODE_PASS;
    endcase
  endfunction

endpackage

@@ hw/rtl/preset_kernel_convolution.sv @@
// Throughput: one item per cycle; ten register stages (window capture, nine MAC cells)
// and the output register each take a new item whenever the stage after them moves.
// Reset: synchronous, active high; clears pixel count, write pointer, stage valids and the
// registers (filter_mode 0, image_width 640). The line memory is not cleared: taps older
// than the frame are masked by the pixel count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// preset_kernel_convolution: 3x3 preset-kernel filter over a raster RGB stream
// Two-line history memory feeding a window register and a chain of nine
// multiply-accumulate cells, then blur scaling and clamp.
// ----------------------------------------------------------------------------
module preset_kernel_convolution (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pkc_pkg::ADDR_W-1:0] paddr,
  input  logic [pkc_pkg::DATA_W-1:0] pwdata,
  output logic [pkc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       pix_valid,
  output logic                       pix_ready,
  input  pkc_pkg::pkc_pix_t          pix,
  output logic                       res_valid,
  input  logic                       res_ready,
  output pkc_pkg::pkc_res_t          res
);
  import pkc_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [2:0]       filter_mode;
  logic [WID_W-1:0] image_width;
  logic [WID_W-1:0] eff_width;   // image_width clipped to 1..MAX_WIDTH
  logic             cfg_wr;
  pkc_reg_t         cfg_reg;
  pkc_mode_t        mode;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_reg = pkc_reg_t'(paddr[2]);
  assign mode    = pkc_mode_of(filter_mode);

  function automatic logic [WID_W-1:0] clip_width(input logic [WID_W-1:0] v);
    if (v == '0) begin
      return WID_W'(1);
    end else if (v > WIDTH_MAX) begin
      return WIDTH_MAX;
    end else begin
      return v;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= MODE_PASS;
      image_width <= WIDTH_RESET;
      eff_width   <= WIDTH_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        REG_FILTER_MODE: begin
          filter_mode <= pwdata[2:0];
        end
        REG_IMAGE_WIDTH: begin
          image_width <= pwdata[WID_W-1:0];
          eff_width   <= clip_width(pwdata[WID_W-1:0]);
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_FILTER_MODE: prdata = DATA_W'(filter_mode);
      REG_IMAGE_WIDTH: prdata = DATA_W'(image_width);
    endcase
  end

  // --------------------------------------------------------------------------
  // Input side: pixel count, window masks, history write
  // --------------------------------------------------------------------------
  logic                  acc;
  logic                  s1_ready;
  pkc_rgb_t              cur;
  pkc_rgb_t              prev1;     // item one back
  pkc_rgb_t              prev2;     // item two back
  pkc_triple_t           triple_next;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  logic [WID_W:0]        row_base [3];
  logic [2:0][2:0]       mask_next;
  logic                  hit;
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_addr_a;
  logic [PTR_W-1:0]      rd_addr_b;
  pkc_triple_t           ram_a;
  pkc_triple_t           ram_b;

  assign pix_ready = s1_ready;
  assign acc       = pix_valid && pix_ready;

  always_comb begin
    // a flush item enters the history as a zero pixel
    if (pix.cmd == CMD_FLUSH) begin
      cur = '0;
    end else begin
      cur = '{red: pix.in_red, green: pix.in_green, blue: pix.in_blue};
    end
    triple_next[0] = cur;
    triple_next[1] = prev1;
    triple_next[2] = prev2;

    // count including this item; frame start restarts it at one, saturate at the top
    if (pix.frame_start) begin
      cnt_next = CNT_W'(1);
    end else if (cnt == CNT_MAX) begin
      cnt_next = cnt;
    end else begin
      cnt_next = cnt + CNT_W'(1);
    end

    // tap (row, col) is the item row*width + col back from this one; it exists
    // in the frame only if the count reaches past it
    row_base[0] = '0;
    row_base[1] = (WID_W+1)'(eff_width);
    row_base[2] = {eff_width, 1'b0};
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        mask_next[a][b] = cnt_next > CNT_W'(row_base[a] + (WID_W+1)'(b));
      end
    end
    // the window centered width+1 back is complete once count >= width + 2
    hit = cnt_next > CNT_W'(row_base[1] + (WID_W+1)'(1));

    // entry width back holds items width..width+2 back, likewise for two rows
    rd_addr_a = wr_ptr - PTR_W'(eff_width);
    rd_addr_b = wr_ptr - PTR_W'({eff_width, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      wr_ptr <= '0;
    end else if (acc) begin
      cnt    <= cnt_next;
      wr_ptr <= wr_ptr + PTR_W'(1);
    end
  end

  // shift the newest items along the short row of the window
  always_ff @(posedge clk) begin
    if (acc) begin
      prev1 <= cur;
      prev2 <= prev1;
    end
  end

  // each entry stores an item with its two predecessors, so one read gives a
  // whole window row; at the widest row a read two widths back wraps onto the
  // write address and returns the old contents
  pkc_line_ram u_ram (
    .clk       (clk),
    .wr_en     (acc),
    .wr_addr   (wr_ptr),
    .wr_data   (triple_next),
    .rd_en     (acc),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (ram_a),
    .rd_data_b (ram_b)
  );

  // --------------------------------------------------------------------------
  // Window capture stage; items that complete no window leave a bubble
  // --------------------------------------------------------------------------
  logic            s1_valid;
  pkc_mode_t       s1_mode;
  logic [2:0][2:0] s1_mask;
  pkc_triple_t     s1_row0;

  logic            c_valid [NCELL+1];
  logic            c_ready [NCELL+1];
  pkc_win_t        c_win   [NCELL+1];

  assign s1_ready = !s1_valid || c_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= acc && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_mode <= mode;
      s1_mask <= mask_next;
      s1_row0 <= triple_next;
    end
  end

  // rows of the window, newest first; sums start at zero
  assign c_valid[0] = s1_valid;
  assign c_win[0]   = '{mode: s1_mode, mask: s1_mask, taps: {ram_b, ram_a, s1_row0},
                        sums: '0};

  // --------------------------------------------------------------------------
  // Chain of MAC cells, one kernel tap per cell
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    pkc_mac_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .row      (2'(j / 3)),
      .col      (2'(j % 3)),
      .up_valid (c_valid[j]),
      .up_ready (c_ready[j]),
      .up_win   (c_win[j]),
      .dn_valid (c_valid[j+1]),
      .dn_ready (c_ready[j+1]),
      .dn_win   (c_win[j+1])
    );
  end

  // --------------------------------------------------------------------------
  // Scale, clamp and hold the result item
  // --------------------------------------------------------------------------
  pkc_post u_post (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (c_valid[NCELL]),
    .up_ready  (c_ready[NCELL]),
    .up_win    (c_win[NCELL]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

`ifndef SYNTHESIS
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    acc && pix.frame_start |=> cnt == CNT_W'(1))
    else $error("pixel count not restarted by frame start");

  a_ptr_step: assert property (@(posedge clk) disable iff (rst)
    acc |=> wr_ptr == PTR_W'($past(wr_ptr) + PTR_W'(1)))
    else $error("write pointer did not advance by one item");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !c_ready[0] |=> s1_valid && $stable(s1_mask) && $stable(s1_row0))
    else $error("window stage changed while stalled");

  a_width_clip: assert property (@(posedge clk) disable iff (rst)
    cfg_wr && cfg_reg == REG_IMAGE_WIDTH |=> eff_width != '0 && eff_width <= WIDTH_MAX)
    else $error("effective width out of range");
`endif

endmodule

@@ hw/rtl/pkc_line_ram.sv @@
// ----------------------------------------------------------------------------
// pkc_line_ram: two-line history memory
// One write port and two registered read ports, read-first on collision.
// ----------------------------------------------------------------------------
module pkc_line_ram (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [pkc_pkg::PTR_W-1:0] wr_addr,
  input  pkc_pkg::pkc_triple_t      wr_data,
  input  logic                      rd_en,
  input  logic [pkc_pkg::PTR_W-1:0] rd_addr_a,
  input  logic [pkc_pkg::PTR_W-1:0] rd_addr_b,
  output pkc_pkg::pkc_triple_t      rd_data_a,
  output pkc_pkg::pkc_triple_t      rd_data_b
);
  import pkc_pkg::*;

  pkc_triple_t mem [RAM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

@@ hw/rtl/pkc_mac_cell.sv @@
// ----------------------------------------------------------------------------
// pkc_mac_cell: one multiply-accumulate cell of the kernel chain
// Adds the weighted tap at (row, col) to the running sums and hands the
// window to the next cell.
// ----------------------------------------------------------------------------
module pkc_mac_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        row,
  input  logic [1:0]        col,
  input  logic              up_valid,
  output logic              up_ready,
  input  pkc_pkg::pkc_win_t up_win,
  output logic              dn_valid,
  input  logic              dn_ready,
  output pkc_pkg::pkc_win_t dn_win
);
  import pkc_pkg::*;

  logic signed [COEF_W-1:0] coef;
  pkc_rgb_t                 tap;
  pkc_win_t                 win_next;

  always_comb begin
    coef     = pkc_coef(up_win.mode, row, col);
    // taps from before the frame start count as zero
    tap      = up_win.mask[row][col] ? up_win.taps[row][col] : '0;
    win_next = up_win;
    win_next.sums[0] = pkc_sum_t'($signed(up_win.sums[0]) + coef * $signed({1'b0, tap.red}));
    win_next.sums[1] = pkc_sum_t'($signed(up_win.sums[1]) + coef * $signed({1'b0, tap.green}));
    win_next.sums[2] = pkc_sum_t'($signed(up_win.sums[2]) + coef * $signed({1'b0, tap.blue}));
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_win <= win_next;
    end
  end

endmodule

@@ hw/rtl/pkc_post.sv @@
// ----------------------------------------------------------------------------
// pkc_post: blur scaling, clamp and output register
// Divides blur sums by nine, clamps each channel to 0..255 and holds the
// result item until it is taken.
// ----------------------------------------------------------------------------
module pkc_post (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  pkc_pkg::pkc_win_t up_win,
  output logic              res_valid,
  input  logic              res_ready,
  output pkc_pkg::pkc_res_t res
);
  import pkc_pkg::*;

  function automatic logic [7:0] finish(input logic [SUM_W-1:0] s, input logic blur);
    logic [2*(SUM_W-1)-1:0] prod;
    logic [SUM_W-1:0]       v;
    prod = s[SUM_W-2:0] * DIV9_MUL;
    v    = blur ? SUM_W'(prod >> DIV9_SHIFT) : s;
    if (v[SUM_W-1]) begin
      return 8'h00;
    end else if (v > SUM_W'(255)) begin
      return 8'hFF;
    end else begin
      return v[7:0];
    end
  endfunction

  logic     blur;
  pkc_res_t res_next;

  always_comb begin
    blur               = (up_win.mode == MODE_BLUR);
    res_next.out_red   = finish(up_win.sums[0], blur);
    res_next.out_green = finish(up_win.sums[1], blur);
    res_next.out_blue  = finish(up_win.sums[2], blur);
  end

  assign up_ready = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (up_ready) begin
      res_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      res <= res_next;
    end
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the preset kernel convolution
// Drives raster RGB items and flush items through the valid/ready input and
// programs and reads back filter mode and row width over the APB port. A
// behavioral copy of the filter computes each filtered pixel as items are
// accepted, and every result item is compared field by field against the
// oldest pending one.
// ----------------------------------------------------------------------------
module testbench;
  import pkc_pkg::*;

  localparam int HIST_DEPTH    = 2 * MAX_WIDTH + 3;  // two rows plus the window corner
  localparam int COUNT_LIMIT   = (1 << 21) - 1;      // frame item count saturates here
  localparam int SETTLE_CYCLES = 16;                 // pipeline latency plus margin
  localparam int HOLD_CYCLES   = 200;                // long receiver hold-off
  localparam int QUIET_LIMIT   = 2000;               // cycles with no handshake at all
  localparam int PRINT_LIMIT   = 100;

  // filter code beyond the defined kernels; the block treats it as pass
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ADDR_W-1:0]   paddr     = '0;
  logic [DATA_W-1:0]   pwdata    = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                pix_valid = 1'b0;
  logic                pix_ready;
  pkc_pix_t            pix       = '0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  pkc_res_t            res;

  preset_kernel_convolution uut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // --------------------------------------------------------------------------
  // Behavioral filter state: register copies, pixel history, frame count
  // --------------------------------------------------------------------------
  logic [2:0]  mode_reg  = MODE_PASS;
  logic [10:0] width_reg = 11'd640;
  pkc_rgb_t    history [HIST_DEPTH];
  int          history_pos = 0;
  int          frame_len   = 0;
  pkc_res_t    filtered_q [$];   // filtered pixels still owed by the block

  int unsigned items_sent   = 0;
  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;
  bit          gaps_on      = 1'b1;
  bit          stalls_on    = 1'b1;
  bit          hold_results = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Row width as the block applies it: zero counts as one, clamp at the top.
  function automatic int active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  // Coefficient for the neighbor at row offset dy, column offset dx.
  function automatic int kernel_weight(input pkc_mode_t mode, input int dy, input int dx);
    case (mode)
      MODE_BLUR:    return 1;
      MODE_EDGE:    return (dy == 0 && dx == 0) ? 8 : -1;
      // emboss grows along the diagonal, except the center which stays 1
      MODE_EMBOSS:  return (dy == 0 && dx == 0) ? 1 : dy + dx;
      MODE_SHARPEN: begin
        if (dy == 0 && dx == 0) return 5;
        return (dy == 0 || dx == 0) ? -1 : 0;
      end
      MODE_ENFORCE: begin
        if (dy == 0 && dx == 0) return 1;
        return (dy == -1 && dx == 0) ? -1 : 0;
      end
      default:      return (dy == 0 && dx == 0) ? 1 : 0;
    endcase
  endfunction

  function automatic logic [7:0] clamp_channel(input int s);
    if (s < 0) return 8'd0;
    if (s > 255) return 8'd255;
    return 8'(s);
  endfunction

  // Store one accepted item and queue the filtered pixel it completes, if any.
  function automatic void filter_pixel(input pkc_pix_t item);
    int        w;
    int        k;
    int        age;
    int        dy;
    int        dx;
    int        sum_r;
    int        sum_g;
    int        sum_b;
    pkc_mode_t mode;
    pkc_rgb_t  px;
    pkc_rgb_t  nb;
    pkc_res_t  out_px;
    w     = active_width();
    mode  = (mode_reg > MODE_ENFORCE) ? MODE_PASS : pkc_mode_t'(mode_reg);
    px    = (item.cmd == CMD_FLUSH) ? pkc_rgb_t'('0) :
            pkc_rgb_t'({item.in_red, item.in_green, item.in_blue});
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    // a frame start drops all earlier history
    if (item.frame_start) frame_len = 0;
    history_pos          = (history_pos + 1) % HIST_DEPTH;
    history[history_pos] = px;
    if (frame_len < COUNT_LIMIT) frame_len++;
    // nothing comes out until the window's lower right corner has arrived
    if (frame_len < w + 2) return;
    for (dy = -1; dy <= 1; dy++) begin
      for (dx = -1; dx <= 1; dx++) begin
        k   = kernel_weight(mode, dy, dx);
        age = w + 1 - (dy * w + dx);
        // neighbors older than the frame count as zero
        if (k != 0 && frame_len >= age + 1) begin
          nb    = history[(history_pos + HIST_DEPTH - age) % HIST_DEPTH];
          sum_r += k * int'(nb.red);
          sum_g += k * int'(nb.green);
          sum_b += k * int'(nb.blue);
        end
      end
    end
    if (mode == MODE_BLUR) begin
      sum_r = sum_r / 9;
      sum_g = sum_g / 9;
      sum_b = sum_b / 9;
    end
    out_px.out_red   = clamp_channel(sum_r);
    out_px.out_green = clamp_channel(sum_g);
    out_px.out_blue  = clamp_channel(sum_b);
    filtered_q.push_back(out_px);
  endfunction

  // Favor the channel extremes so clamping and zero paths get hit often.
  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Shared driver tasks
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int want, input int got);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("mismatch: %s expected %0d got %0d at %0t", what, want, got, $time);
  endtask

  // APB write; random upper data bits must be dropped by the register.
  task automatic write_reg(input pkc_reg_t idx, input logic [31:0] value);
    logic [31:0] keep;
    logic [31:0] data;
    keep = (idx == REG_FILTER_MODE) ? 32'h7 : 32'h7FF;
    data = (value & keep) | ($urandom() & ~keep);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_FILTER_MODE) mode_reg = data[2:0];
    else width_reg = data[10:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // APB read; the register must return the value last written.
  task automatic read_reg(input pkc_reg_t idx);
    logic [31:0] want;
    want    = (idx == REG_FILTER_MODE) ? 32'(mode_reg) : 32'(width_reg);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(idx) << 2;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) report_mismatch("prdata", int'(want), int'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one item and hold it until accepted. Valid stays high afterwards
  // so back-to-back items go out without a bubble; wait_drain drops it.
  task automatic send_item(input pkc_pix_t item);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      pix_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix       <= item;
    do @(posedge clk); while (!pix_ready);
    filter_pixel(item);
    items_sent++;
  endtask

  // Stop offering, wait for every owed result, then let the pipeline settle.
  task automatic wait_drain();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Send a run of pixels followed by flush items. In noisy runs some items
  // flip their command and a few start a new frame part way through.
  task automatic run_frame(input int pixels, input int tail, input bit new_frame,
                           input bit noisy);
    pkc_pix_t item;
    for (int i = 0; i < pixels + tail; i++) begin
      item.cmd         = (i < pixels) ? CMD_PIXEL : CMD_FLUSH;
      item.frame_start = (i == 0) && new_frame;
      if (noisy && $urandom_range(0, 19) == 0) item.cmd = ~item.cmd;
      if (noisy && $urandom_range(0, 49) == 0) item.frame_start = 1'b1;
      // flush items carry random data, which the block must ignore
      item.in_red      = pick_channel();
      item.in_green    = pick_channel();
      item.in_blue     = pick_channel();
      send_item(item);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Out of reset: pass mode, rows of 640. Both registers read back their
  // reset values, and a short frame completes no window.
  task automatic test_reset_defaults();
    read_reg(REG_FILTER_MODE);
    read_reg(REG_IMAGE_WIDTH);
    run_frame(40, 0, 1'b1, 1'b0);
  endtask

  // Every filter code on a one-pixel row, with saturated and mixed channels.
  // Width zero is written so it must act as one. The last code starts its
  // frame with a flush item.
  task automatic test_directed();
    pkc_pix_t item;
    wait_drain();
    write_reg(REG_IMAGE_WIDTH, 0);
    for (int code = 0; code < 8; code++) begin
      wait_drain();
      write_reg(REG_FILTER_MODE, code);
      item = '{cmd: (code == MODE_SPARE_HI) ? CMD_FLUSH : CMD_PIXEL, frame_start: 1'b1,
               in_red: 8'hFF, in_green: 8'hFF, in_blue: 8'hFF};
      send_item(item);
      item = '{cmd: CMD_PIXEL, frame_start: 1'b0,
               in_red: 8'h00, in_green: 8'hFF, in_blue: 8'h80};
      send_item(item);
      item = '{cmd: CMD_FLUSH, frame_start: 1'b0,
               in_red: pick_channel(), in_green: pick_channel(), in_blue: pick_channel()};
      send_item(item);
    end
  endtask

  // Oversized width register value must clamp to the widest row. Its low ten
  // bits give a row of six, so a short frame shows a dropped top bit at once.
  task automatic test_wide_rows();
    wait_drain();
    write_reg(REG_FILTER_MODE, MODE_EDGE);
    write_reg(REG_IMAGE_WIDTH, 1030);
    read_reg(REG_IMAGE_WIDTH);
    run_frame(40, 0, 1'b1, 1'b0);
  endtask

  // Hold results off long enough for the block to stall its input, then
  // pause the sender until all results are back and resume the same frame.
  task automatic test_backpressure();
    wait_drain();
    gaps_on   = 1'b0;
    stalls_on = 1'b1;
    write_reg(REG_FILTER_MODE, MODE_SHARPEN);
    write_reg(REG_IMAGE_WIDTH, 5);
    hold_results = 1'b1;
    run_frame(60, 0, 1'b1, 1'b0);
    wait_drain();
    gaps_on = 1'b1;
    run_frame(30, 6, 1'b0, 1'b0);
  endtask

  // Random phases: new mode each phase, new width most phases, mostly small
  // rows. Phases without a frame start keep history across a width change.
  task automatic test_random_frames(input int unsigned budget, input bit idle);
    int unsigned first;
    int          w;
    int          left;
    int          pixels;
    first = items_sent;
    while (items_sent - first < budget) begin
      wait_drain();
      gaps_on   = idle && ($urandom_range(0, 3) != 0);
      stalls_on = idle && ($urandom_range(0, 3) != 0);
      write_reg(REG_FILTER_MODE, $urandom_range(0, 7));
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 19))
          0:       w = 0;
          1, 2, 3: w = $urandom_range(13, 64);
          default: w = $urandom_range(1, 12);
        endcase
        write_reg(REG_IMAGE_WIDTH, w);
      end
      w      = active_width();
      left   = int'(budget - (items_sent - first));
      pixels = w * $urandom_range(1, 5);
      if (pixels > left) pixels = left;
      run_frame(pixels, w + 1 + $urandom_range(0, 2),
                $urandom_range(0, 7) != 0, $urandom_range(0, 1));
    end
  endtask

  // --------------------------------------------------------------------------
  // Result receiver: random stalls, open stretches, and the long hold-off
  // --------------------------------------------------------------------------
  initial begin
    @(posedge clk);
    forever begin
      if (hold_results) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        res_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest owed filtered pixel.
  always @(posedge clk) begin
    pkc_res_t want;
    if (!rst && res_valid && res_ready) begin
      if (filtered_q.size() == 0) begin
        report_mismatch("result with none pending", -1, int'(res));
      end else begin
        want = filtered_q.pop_front();
        if (res.out_red !== want.out_red)
          report_mismatch("out_red", want.out_red, res.out_red);
        if (res.out_green !== want.out_green)
          report_mismatch("out_green", want.out_green, res.out_green);
        if (res.out_blue !== want.out_blue)
          report_mismatch("out_blue", want.out_blue, res.out_blue);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (pix_valid && pix_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    foreach (history[i]) history[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_directed();
    test_wide_rows();
    test_backpressure();
    test_random_frames(330, 1'b1);
    // last part runs with no idling on either side
    test_random_frames(100, 1'b0);
    wait_drain();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/pkc_pkg.sv
hw/rtl/pkc_line_ram.sv
hw/rtl/pkc_mac_cell.sv
hw/rtl/pkc_post.sv
hw/rtl/preset_kernel_convolution.sv
tb/testbench.sv
